// ===== rtl/gdma_pkg.sv =====
// shared types and constants for the gyro deadband moving average filter
package gdma_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int DB_W         = 15;
    localparam int MEAN_W       = 20;
    localparam int FRAC_BITS    = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int TAPS_DEFAULT = 12;

    localparam logic [DB_W-1:0] DEADBAND_RESET = 15'd30;

    typedef enum logic {
        CH_Y = 1'b0,
        CH_Z = 1'b1
    } chan_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS_Y   = 2'd0,
        REG_BIAS_Z   = 2'd1,
        REG_DEADBAND = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                        valid;
        chan_t                       ch;
        logic signed [SAMPLE_W-1:0]  value;
    } hist_push_t;

endpackage

// ===== rtl/gyro_deadband_moving_average_top.sv =====
// Two-channel (Y/Z) gyro filter: bias removal, deadband and a TAPS-deep moving
// average reported in Q.4. One item is accepted per clock cycle when the output
// side keeps up; each item yields one result after passing through the input
// register, history update, magnitude, reciprocal multiply and output register
// stages. The window sum of each channel is kept as a running total updated
// in the cycle the item leaves the input register, so items of the same channel
// may follow each other back to back. Division by TAPS is a multiplication by a
// rounded-up reciprocal, exact for every window sum. Histories clear at reset.
module gyro_deadband_moving_average_top
    import gdma_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  logic signed [SAMPLE_W-1:0]  raw_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  corrected_sample,
    output logic signed [MEAN_W-1:0]    mean_q4,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int TAP_BITS = $clog2(TAPS);
    localparam int SUM_W    = SAMPLE_W + TAP_BITS;
    localparam int MAG_W    = SUM_W + FRAC_BITS;
    localparam int RECIP_SH = MAG_W + TAP_BITS;
    localparam int PROD_W   = MAG_W + RECIP_SH;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(TAPS) - 64'd1) / 64'(TAPS);
    localparam logic [RECIP_SH-1:0] RECIP = RECIP_FULL[RECIP_SH-1:0];

    // configuration
    logic signed [SAMPLE_W-1:0] bias_y_reg;
    logic signed [SAMPLE_W-1:0] bias_z_reg;
    logic [DB_W-1:0]            deadband_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_y_reg   <= '0;
            bias_z_reg   <= '0;
            deadband_reg <= DEADBAND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIAS_Y:   bias_y_reg   <= cfg_data[SAMPLE_W-1:0];
                REG_BIAS_Z:   bias_z_reg   <= cfg_data[SAMPLE_W-1:0];
                REG_DEADBAND: deadband_reg <= cfg_data[DB_W-1:0];
                default:      ;
            endcase
        end
    end

    // pipeline valid bits and stage ready chain
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic d_valid_reg;
    logic o_valid_reg;
    logic b_rdy;
    logic c_rdy;
    logic d_rdy;
    logic o_rdy;

    assign o_rdy    = !o_valid_reg || out_ready;
    assign d_rdy    = !d_valid_reg || o_rdy;
    assign c_rdy    = !c_valid_reg || d_rdy;
    assign b_rdy    = !b_valid_reg || c_rdy;
    assign in_ready = !a_valid_reg || b_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready) a_valid_reg <= in_valid;
            if (b_rdy)    b_valid_reg <= a_valid_reg;
            if (c_rdy)    c_valid_reg <= b_valid_reg;
            if (d_rdy)    d_valid_reg <= c_valid_reg;
            if (o_rdy)    o_valid_reg <= d_valid_reg;
        end
    end

    // stage a: input register
    chan_t                      a_type_reg;
    logic signed [SAMPLE_W-1:0] a_raw_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_type_reg <= chan_t'(req_type);
            a_raw_reg  <= raw_sample;
        end
    end

    // bias removal and deadband
    logic signed [SAMPLE_W-1:0] bias;
    logic signed [SAMPLE_W-1:0] diff;
    logic signed [SAMPLE_W:0]   diff_x;
    logic signed [SAMPLE_W:0]   db_x;
    logic signed [SAMPLE_W-1:0] kept;
    logic signed [SUM_W-1:0]    sum_new;
    hist_push_t                 push;

    assign bias   = (a_type_reg == CH_Z) ? bias_z_reg : bias_y_reg;
    assign diff   = a_raw_reg - bias;
    assign diff_x = (SAMPLE_W+1)'(diff);
    assign db_x   = $signed({2'b00, deadband_reg});
    assign kept   = (diff_x > -db_x && diff_x < db_x) ? '0 : diff;

    assign push.valid = a_valid_reg && b_rdy;
    assign push.ch    = a_type_reg;
    assign push.value = kept;

    gdma_hist #(
        .TAPS  (TAPS),
        .SUM_W (SUM_W)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .sum_new (sum_new)
    );

    // stage b: corrected value and window sum
    logic signed [SAMPLE_W-1:0] b_corr_reg;
    logic signed [SUM_W-1:0]    b_sum_reg;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            b_corr_reg <= diff;
            b_sum_reg  <= sum_new;
        end
    end

    // stage c: sign and scaled magnitude
    logic [SUM_W-1:0]           b_abs;
    logic                       c_neg_reg;
    logic [MAG_W-1:0]           c_mag_reg;
    logic signed [SAMPLE_W-1:0] c_corr_reg;

    assign b_abs = b_sum_reg[SUM_W-1] ? SUM_W'(-b_sum_reg) : SUM_W'(b_sum_reg);

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && c_rdy)
        begin
            c_neg_reg  <= b_sum_reg[SUM_W-1];
            c_mag_reg  <= {b_abs, {FRAC_BITS{1'b0}}};
            c_corr_reg <= b_corr_reg;
        end
    end

    // stage d: multiply by rounded-up reciprocal of TAPS
    logic [PROD_W-1:0]          d_prod_reg;
    logic                       d_neg_reg;
    logic signed [SAMPLE_W-1:0] d_corr_reg;

    always_ff @(posedge clk)
    begin
        if (c_valid_reg && d_rdy)
        begin
            d_prod_reg <= PROD_W'(c_mag_reg) * PROD_W'(RECIP);
            d_neg_reg  <= c_neg_reg;
            d_corr_reg <= c_corr_reg;
        end
    end

    // output register: truncate toward zero by restoring the sign
    logic [MAG_W-1:0]           quot;
    logic [MAG_W-1:0]           quot_signed;
    logic signed [MEAN_W-1:0]   mean_next;
    logic signed [SAMPLE_W-1:0] o_corr_reg;
    logic signed [MEAN_W-1:0]   o_mean_reg;

    assign quot        = d_prod_reg[RECIP_SH +: MAG_W];
    assign quot_signed = d_neg_reg ? -quot : quot;
    assign mean_next   = quot_signed[MEAN_W-1:0];

    always_ff @(posedge clk)
    begin
        if (d_valid_reg && o_rdy)
        begin
            o_corr_reg <= d_corr_reg;
            o_mean_reg <= mean_next;
        end
    end

    assign out_valid        = o_valid_reg;
    assign corrected_sample = o_corr_reg;
    assign mean_q4          = o_mean_reg;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> a_valid_reg)
        else $error("accepted item missing from input register");

    a_stall_a: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_rdy |=> a_valid_reg && $stable(a_raw_reg) && $stable(a_type_reg))
        else $error("input register lost an item while stalled");

    a_stall_b: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !c_rdy |=> b_valid_reg && $stable(b_sum_reg))
        else $error("window sum stage lost an item while stalled");

    a_stall_d: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && !o_rdy |=> d_valid_reg && $stable(d_prod_reg))
        else $error("product stage lost an item while stalled");

endmodule

// ===== rtl/gdma_hist.sv =====
// per-channel sample history shift lines with running window sums
module gdma_hist
    import gdma_pkg::*;
#(
    parameter int TAPS  = TAPS_DEFAULT,
    parameter int SUM_W = SAMPLE_W + $clog2(TAPS)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  hist_push_t               push,
    output logic signed [SUM_W-1:0]  sum_new
);

    logic signed [SAMPLE_W-1:0] y_hist_reg [TAPS];
    logic signed [SAMPLE_W-1:0] z_hist_reg [TAPS];
    logic signed [SUM_W-1:0]    sum_y_reg;
    logic signed [SUM_W-1:0]    sum_z_reg;
    logic signed [SAMPLE_W-1:0] val;
    logic signed [SAMPLE_W-1:0] oldest;
    logic signed [SUM_W-1:0]    sum_old;

    assign val     = push.value;
    assign oldest  = (push.ch == CH_Z) ? z_hist_reg[TAPS-1] : y_hist_reg[TAPS-1];
    assign sum_old = (push.ch == CH_Z) ? sum_z_reg : sum_y_reg;

    // window sum after the push: drop the oldest entry, add the new one
    assign sum_new = sum_old - SUM_W'(oldest) + SUM_W'(val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                y_hist_reg[i] <= '0;
                z_hist_reg[i] <= '0;
            end
            sum_y_reg <= '0;
            sum_z_reg <= '0;
        end
        else if (push.valid)
        begin
            if (push.ch == CH_Z)
            begin
                for (int i = TAPS - 1; i >= 1; i--)
                begin
                    z_hist_reg[i] <= z_hist_reg[i-1];
                end
                z_hist_reg[0] <= val;
                sum_z_reg     <= sum_new;
            end
            else
            begin
                for (int i = TAPS - 1; i >= 1; i--)
                begin
                    y_hist_reg[i] <= y_hist_reg[i-1];
                end
                y_hist_reg[0] <= val;
                sum_y_reg     <= sum_new;
            end
        end
    end

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !push.valid |=> $stable(sum_y_reg) && $stable(sum_z_reg))
        else $error("window sum changed without a push");

    a_y_leaves_z: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && push.ch == CH_Y |=> $stable(sum_z_reg) && $stable(z_hist_reg[0]))
        else $error("y push disturbed z channel");

    a_z_leaves_y: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && push.ch == CH_Z |=> $stable(sum_y_reg) && $stable(y_hist_reg[0]))
        else $error("z push disturbed y channel");

endmodule
